FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define RHLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RHLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rhlc_pkg.sv
// shared constants and codes of the resource handle lifecycle checker
// no dependencies
`timescale 1ns / 1ps

package rhlc_pkg;

  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int DOMAIN_COUNT_DEF = 8;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_USE     = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_REALLOC = 3'd3;
  localparam logic [2:0] ACT_REPORT  = 3'd4;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_DOUBLE_ALLOC  = 4'd1;
  localparam logic [3:0] ST_BAD_USE       = 4'd2;
  localparam logic [3:0] ST_UNALLOC_USE   = 4'd3;
  localparam logic [3:0] ST_USE_AFTER_FREE = 4'd4;
  localparam logic [3:0] ST_FREE_UNALLOC  = 4'd5;
  localparam logic [3:0] ST_FREE_UNUSED   = 4'd6;
  localparam logic [3:0] ST_DOUBLE_FREE   = 4'd7;
  localparam logic [3:0] ST_REALLOC_UNKNOWN = 4'd8;
  localparam logic [3:0] ST_REALLOC_AMBIG = 4'd9;
  localparam logic [3:0] ST_REALLOC_SAME  = 4'd10;
  localparam logic [3:0] ST_TABLE_FULL    = 4'd11;
  localparam logic [3:0] ST_LEAK_UNUSED   = 4'd12;
  localparam logic [3:0] ST_LEAK_USED     = 4'd13;
  localparam logic [3:0] ST_NO_LEAKS      = 4'd14;

  localparam logic [1:0] LIFE_ALLOC = 2'd1;
  localparam logic [1:0] LIFE_USED  = 2'd2;
  localparam logic [1:0] LIFE_FREED = 2'd3;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_BYTE_SIZED = 3'd0;

endpackage

FILE: hw/rtl/rhlc_ifs.sv
// valid/ready channel interfaces for input and result words
// depends on nothing
`timescale 1ns / 1ps

interface rhlc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  domain;
  logic [63:0] handle;
  logic        handle_good;
  logic [63:0] length;
  logic        call_succeeded;
  logic [63:0] new_handle;

  modport source (output valid, action, domain, handle, handle_good, length,
                  call_succeeded, new_handle, input ready);
  modport sink (input valid, action, domain, handle, handle_good, length,
                call_succeeded, new_handle, output ready);
endinterface

interface rhlc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        zero_length_warning;
  logic [63:0] result_handle;
  logic [63:0] result_length;
  logic [2:0]  result_domain;
  logic        last;

  modport source (output valid, status, zero_length_warning, result_handle,
                  result_length, result_domain, last, input ready);
  modport sink (input valid, status, zero_length_warning, result_handle,
                result_length, result_domain, last, output ready);
endinterface

FILE: hw/rtl/resource_handle_lifecycle_checker_core.sv
// Handle table checker: allocate, use, free and reallocate events are checked against a
// table of handles, one entry read at a time (S_RD, then S_CMP) from the table memory.
// An event scans every filled entry, or none when no search is needed; a leak report scans
// every filled entry once per domain. Both hold while the result register is stalled.
// The table needs no clearing after reset; only entries below the fill count are compared.
// Depends on rhlc_pkg, rhlc_ifs and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module resource_handle_lifecycle_checker_core
  import rhlc_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int DOMAIN_COUNT = DOMAIN_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rhlc_in_if.sink           in_if,
  rhlc_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_FIN  = 5'b01000,
    S_RFIN = 5'b10000
  } state_t;

  state_t state_r;

  logic [63:0] mem_h [TABLE_DEPTH];
  logic [63:0] mem_l [TABLE_DEPTH];
  logic [2:0]  mem_d [TABLE_DEPTH];
  logic [1:0]  mem_life [TABLE_DEPTH];

  logic [63:0] rd_h_r, rd_l_r;
  logic [2:0]  rd_d_r;
  logic [1:0]  rd_life_r;

  logic [7:0]    bsd_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [2:0]    dscan_r;

  logic [2:0]  q_act_r, q_dom_r;
  logic [63:0] q_h_r, q_len_r, q_nh_r;
  logic        q_good_r, q_ok_r, q_oor_r;

  logic          hit_r;
  logic [AW-1:0] last_idx_r, first_idx_r;
  logic [1:0]    last_life_r, acnt_r;
  logic [63:0]   first_len_r;

  logic        pend_v_r;
  logic [3:0]  pend_st_r;
  logic [63:0] pend_h_r, pend_l_r;
  logic [2:0]  pend_d_r;

  logic        out_v_r, out_zw_r, out_last_r;
  logic [3:0]  out_st_r;
  logic [63:0] out_h_r, out_l_r;
  logic [2:0]  out_d_r;

  logic          out_free, cfg_wr, out_load;
  logic [63:0]   key, sl;
  logic          byte_dom, is_alloc, do_free_path, leak, adv, scan_end;
  logic [3:0]    fin_st;
  logic          fin_zw, count_inc;
  logic [63:0]   fin_h;
  logic [AW-1:0] wr_addr;
  logic          we_h, we_l, we_d, we_life;
  logic [63:0]   wd_h, wd_l;
  logic [1:0]    wd_life;
  logic          in_skip;

  assign out_free  = !out_v_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_BYTE_SIZED) ? {24'd0, bsd_r} : 32'd0;

  assign out_if.valid = out_v_r;
  assign out_if.status = out_st_r;
  assign out_if.zero_length_warning = out_zw_r;
  assign out_if.result_handle = out_h_r;
  assign out_if.result_length = out_l_r;
  assign out_if.result_domain = out_d_r;
  assign out_if.last = out_last_r;

  assign key = (q_act_r == ACT_REALLOC && !q_good_r) ? q_nh_r : q_h_r;
  assign byte_dom = bsd_r[q_dom_r];
  assign sl = byte_dom ? q_len_r : 64'd0;
  assign leak = (rd_d_r == dscan_r) && (rd_life_r != LIFE_FREED);
  assign adv = !leak || !pend_v_r || out_free;
  assign scan_end = ((idx_r + CW'(1)) == count_r);

  // result register loads a new word
  assign out_load = ((state_r == S_CMP) && (q_act_r == ACT_REPORT) && leak && pend_v_r &&
                     out_free) ||
                    ((state_r == S_FIN || state_r == S_RFIN) && out_free);

  assign in_skip = ({1'b0, in_if.domain} >= 4'(DOMAIN_COUNT)) ||
                   (in_if.action == ACT_USE && !in_if.handle_good) ||
                   (in_if.action == ACT_REALLOC && !in_if.handle_good &&
                    !in_if.call_succeeded) ||
                   (count_r == '0);

  // result and table update at the end of an event
  always_comb begin
    fin_st = ST_OK;
    fin_zw = 1'b0;
    fin_h = q_h_r;
    count_inc = 1'b0;
    wr_addr = last_idx_r;
    we_h = 1'b0;
    we_l = 1'b0;
    we_d = 1'b0;
    we_life = 1'b0;
    wd_h = q_h_r;
    wd_l = sl;
    wd_life = LIFE_FREED;
    is_alloc = (q_act_r == ACT_ALLOC) ||
               (q_act_r == ACT_REALLOC && !q_good_r && q_ok_r);
    do_free_path = 1'b0;
    if (q_oor_r) begin
      fin_st = ST_OK;
    end else if (is_alloc) begin
      fin_h = key;
      fin_zw = (q_len_r == 64'd0) && byte_dom;
      if (acnt_r != 2'd0) begin
        fin_st = ST_DOUBLE_ALLOC;
      end else if (count_r >= CW'(TABLE_DEPTH)) begin
        fin_st = ST_TABLE_FULL;
      end else begin
        wr_addr = count_r[AW-1:0];
        wd_h = key;
        wd_life = LIFE_ALLOC;
        we_h = 1'b1;
        we_l = 1'b1;
        we_d = 1'b1;
        we_life = 1'b1;
        count_inc = 1'b1;
      end
    end else if (q_act_r == ACT_USE) begin
      if (!q_good_r) fin_st = ST_BAD_USE;
      else if (!hit_r) fin_st = ST_UNALLOC_USE;
      else if (last_life_r == LIFE_FREED) fin_st = ST_USE_AFTER_FREE;
      else begin
        wd_life = LIFE_USED;
        we_life = 1'b1;
      end
    end else if (q_act_r == ACT_FREE) begin
      do_free_path = 1'b1;
    end else if (q_act_r == ACT_REALLOC && q_good_r) begin
      if (acnt_r == 2'd0) fin_st = ST_REALLOC_UNKNOWN;
      else if (acnt_r != 2'd1) fin_st = ST_REALLOC_AMBIG;
      else if (q_len_r == 64'd0) do_free_path = 1'b1;
      else begin
        fin_st = (sl == first_len_r) ? ST_REALLOC_SAME : ST_OK;
        wr_addr = first_idx_r;
        wd_h = q_nh_r;
        we_h = q_ok_r;
        we_l = q_ok_r;
      end
    end
    if (do_free_path) begin
      wr_addr = last_idx_r;
      wd_life = LIFE_FREED;
      if (!hit_r) fin_st = ST_FREE_UNALLOC;
      else if (last_life_r == LIFE_FREED) fin_st = ST_DOUBLE_FREE;
      else begin
        we_life = 1'b1;
        fin_st = (last_life_r == LIFE_ALLOC) ? ST_FREE_UNUSED : ST_OK;
      end
    end
  end

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      if (we_h) mem_h[wr_addr] <= wd_h;
      if (we_l) mem_l[wr_addr] <= wd_l;
      if (we_d) mem_d[wr_addr] <= q_dom_r;
      if (we_life) mem_life[wr_addr] <= wd_life;
    end
    rd_h_r <= mem_h[idx_r[AW-1:0]];
    rd_l_r <= mem_l[idx_r[AW-1:0]];
    rd_d_r <= mem_d[idx_r[AW-1:0]];
    rd_life_r <= mem_life[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bsd_r <= 8'd0;
      out_v_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr == REG_BYTE_SIZED) bsd_r <= cfg_pwdata[7:0];
      if (out_load) out_v_r <= 1'b1;
      else if (out_if.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid && in_if.action <= ACT_REPORT) begin
            q_act_r <= in_if.action;
            q_dom_r <= in_if.domain;
            q_h_r <= in_if.handle;
            q_good_r <= in_if.handle_good;
            q_len_r <= in_if.length;
            q_ok_r <= in_if.call_succeeded;
            q_nh_r <= in_if.new_handle;
            q_oor_r <= ({1'b0, in_if.domain} >= 4'(DOMAIN_COUNT));
            idx_r <= '0;
            dscan_r <= 3'd0;
            hit_r <= 1'b0;
            acnt_r <= 2'd0;
            if (in_if.action == ACT_REPORT) begin
              state_r <= (count_r == '0) ? S_RFIN : S_RD;
            end else begin
              state_r <= in_skip ? S_FIN : S_RD;
            end
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (q_act_r == ACT_REPORT) begin
            if (leak) begin
              if (pend_v_r && out_free) begin
                out_st_r <= pend_st_r;
                out_zw_r <= 1'b0;
                out_h_r <= pend_h_r;
                out_l_r <= pend_l_r;
                out_d_r <= pend_d_r;
                out_last_r <= 1'b0;
              end
              if (adv) begin
                pend_v_r <= 1'b1;
                pend_st_r <= (rd_life_r == LIFE_ALLOC) ? ST_LEAK_UNUSED : ST_LEAK_USED;
                pend_h_r <= rd_h_r;
                pend_l_r <= rd_l_r;
                pend_d_r <= rd_d_r;
              end
            end
            if (adv) begin
              if (!scan_end) begin
                idx_r <= idx_r + CW'(1);
                state_r <= S_RD;
              end else if (dscan_r == 3'(DOMAIN_COUNT - 1)) begin
                state_r <= S_RFIN;
              end else begin
                dscan_r <= dscan_r + 3'd1;
                idx_r <= '0;
                state_r <= S_RD;
              end
            end
          end else begin
            if (rd_d_r == q_dom_r && rd_h_r == key) begin
              hit_r <= 1'b1;
              last_idx_r <= idx_r[AW-1:0];
              last_life_r <= rd_life_r;
              if (rd_life_r == LIFE_ALLOC) begin
                if (acnt_r == 2'd0) begin
                  first_idx_r <= idx_r[AW-1:0];
                  first_len_r <= rd_l_r;
                end
                if (acnt_r != 2'd2) acnt_r <= acnt_r + 2'd1;
              end
            end
            if (scan_end) state_r <= S_FIN;
            else begin
              idx_r <= idx_r + CW'(1);
              state_r <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_st_r <= fin_st;
            out_zw_r <= fin_zw;
            out_h_r <= fin_h;
            out_l_r <= 64'd0;
            out_d_r <= q_dom_r;
            out_last_r <= 1'b1;
            if (count_inc) count_r <= count_r + CW'(1);
            state_r <= S_IDLE;
          end
        end
        S_RFIN: begin
          if (out_free) begin
            out_zw_r <= 1'b0;
            out_last_r <= 1'b1;
            if (pend_v_r) begin
              out_st_r <= pend_st_r;
              out_h_r <= pend_h_r;
              out_l_r <= pend_l_r;
              out_d_r <= pend_d_r;
            end else begin
              out_st_r <= ST_NO_LEAKS;
              out_h_r <= 64'd0;
              out_l_r <= 64'd0;
              out_d_r <= 3'd0;
            end
            pend_v_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RHLC_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(TABLE_DEPTH), "table count over depth")
  `RHLC_ASSERT(a_count_step, clk, rst_n, (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1)), "table count jumped")
  `RHLC_ASSERT(a_out_src, clk, rst_n, $rose(out_v_r) |-> ($past(state_r) == S_FIN || $past(state_r) == S_CMP || $past(state_r) == S_RFIN), "word raised outside result states")
  `RHLC_ASSERT_ALWAYS(a_pend_report, clk, pend_v_r |-> (q_act_r == ACT_REPORT && (state_r == S_RD || state_r == S_CMP || state_r == S_RFIN)) || !rst_n || !$past(rst_n), "pending leak outside report")

endmodule
